### rtl/core/pressure_temperature_compensation_defines.svh
// Assertion macros shared by the compensation RTL
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off while rst_n is low
`define PTC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// Next-cycle implication, checked on clk, off while rst_n is low
`define PTC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define PTC_ASSERT_IMP(label, ante, cons)
`define PTC_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/core/ptc_pkg.sv
// Shared widths, constants, register codes and stage types for the compensation pipeline
package ptc_pkg;

    // Port field widths
    localparam int unsigned RAW_W     = 24;
    localparam int unsigned COEF_W    = 16;
    localparam int unsigned LIMIT_W   = 32;
    localparam int unsigned TEMP_W    = 19;
    localparam int unsigned PRES_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Internal datapath widths
    localparam int unsigned DT_W    = RAW_W + 1;          // D2 - C5*256
    localparam int unsigned DEV_W   = 18;                 // TEMP - 2000
    localparam int unsigned OFF1_W  = 36;                 // first-order offset
    localparam int unsigned SENS1_W = 35;                 // first-order sensitivity
    localparam int unsigned SQ_W    = 2 * DEV_W - 1;      // squared deviation
    localparam int unsigned TERM_W  = SQ_W + 3;           // second-order terms
    localparam int unsigned FIN_W   = 39;                 // corrected offset and sensitivity

    // Temperature constants
    localparam logic signed [TEMP_W-1:0] TEMP_REF      = 19'sd2000;
    localparam logic signed [DEV_W-1:0]  VERY_COLD_DEV = -18'sd3500;
    localparam logic signed [DEV_W-1:0]  COLD_SHIFT    = 18'sd3500;

    // Reset value of the upper pressure limit
    localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RST = 32'sd140000;

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS       = 3'd0,
        REG_OFF        = 3'd1,
        REG_SENS_TEMP  = 3'd2,
        REG_OFF_TEMP   = 3'd3,
        REG_REF_TEMP   = 3'd4,
        REG_TEMP_SLOPE = 3'd5,
        REG_LOW_LIMIT  = 3'd6,
        REG_HIGH_LIMIT = 3'd7
    } cfg_idx_t;

    // Calibration words and pressure window
    typedef struct packed {
        logic [COEF_W-1:0]         sens_coef;
        logic [COEF_W-1:0]         off_coef;
        logic [COEF_W-1:0]         sens_temp_coef;
        logic [COEF_W-1:0]         off_temp_coef;
        logic [COEF_W-1:0]         ref_temp_coef;
        logic [COEF_W-1:0]         temp_slope_coef;
        logic signed [LIMIT_W-1:0] pressure_low_limit;
        logic signed [LIMIT_W-1:0] pressure_high_limit;
    } cfg_t;

    // First-order results handed to the correction stages
    typedef struct packed {
        logic [RAW_W-1:0]          raw_pressure;
        logic signed [TEMP_W-1:0]  temperature;
        logic signed [DEV_W-1:0]   dev;
        logic signed [DEV_W-1:0]   cold;
        logic signed [OFF1_W-1:0]  off;
        logic signed [SENS1_W-1:0] sens;
        logic                      cold_range;
        logic                      very_cold;
    } first_order_t;

    // Corrected terms handed to the pressure stages
    typedef struct packed {
        logic [RAW_W-1:0]         raw_pressure;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [FIN_W-1:0]  off;
        logic signed [FIN_W-1:0]  sens;
    } second_order_t;

endpackage

### rtl/core/ptc_if.sv
// Valid/ready channels for raw sample requests and compensated result requests
interface ptc_sample_if import ptc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_result_if import ptc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [PRES_W-1:0] pressure;
    logic                     pressure_ok;

    modport source (output valid, output temperature, output pressure, output pressure_ok,
                    input ready);
    modport sink (input valid, input temperature, input pressure, input pressure_ok,
                  output ready);
endinterface

### rtl/core/pressure_temperature_compensation.sv
// Top level of the second-order pressure/temperature compensation pipeline.
// A request passes through the first-order, second-order and pressure stages in turn.
// Throughput: one request per cycle while results are taken; ten register stages, each holding one request.
// A stalled result backs the pipeline up one stage at a time; empty stages keep filling.
// Reset clears all stage valid bits and calibration words; the high limit resets to 140000.
`include "pressure_temperature_compensation_defines.svh"
module pressure_temperature_compensation import ptc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [LIMIT_W-1:0]   wr_data,
    ptc_sample_if.sink           sample,
    ptc_result_if.source         result
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic          fo_valid, fo_ready;
    first_order_t  fo_data;
    logic          so_valid, so_ready;
    second_order_t so_data;

    // Decode a configuration write
    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg_idx_t'(wr_index))
            REG_SENS:       cfg_next.sens_coef           = wr_data[COEF_W-1:0];
            REG_OFF:        cfg_next.off_coef            = wr_data[COEF_W-1:0];
            REG_SENS_TEMP:  cfg_next.sens_temp_coef      = wr_data[COEF_W-1:0];
            REG_OFF_TEMP:   cfg_next.off_temp_coef       = wr_data[COEF_W-1:0];
            REG_REF_TEMP:   cfg_next.ref_temp_coef       = wr_data[COEF_W-1:0];
            REG_TEMP_SLOPE: cfg_next.temp_slope_coef     = wr_data[COEF_W-1:0];
            REG_LOW_LIMIT:  cfg_next.pressure_low_limit  = $signed(wr_data);
            REG_HIGH_LIMIT: cfg_next.pressure_high_limit = $signed(wr_data);
            default:        cfg_next = cfg_reg;
        endcase
    end

    // Hold calibration words and limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pressure_high_limit: HIGH_LIMIT_RST, default: '0};
        end
        else if (wr_en)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // First-order stages
    ptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (sample.valid),
        .in_ready        (sample.ready),
        .raw_pressure    (sample.raw_pressure),
        .raw_temperature (sample.raw_temperature),
        .out_valid       (fo_valid),
        .out_ready       (fo_ready),
        .out_data        (fo_data)
    );

    // Second-order correction stages
    ptc_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fo_valid),
        .in_ready  (fo_ready),
        .in_data   (fo_data),
        .out_valid (so_valid),
        .out_ready (so_ready),
        .out_data  (so_data)
    );

    // Pressure stages and output register
    ptc_press u_press (
        .clk         (clk),
        .rst_n       (rst_n),
        .low_limit   (cfg_reg.pressure_low_limit),
        .high_limit  (cfg_reg.pressure_high_limit),
        .in_valid    (so_valid),
        .in_ready    (so_ready),
        .in_data     (so_data),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .temperature (result.temperature),
        .pressure    (result.pressure),
        .pressure_ok (result.pressure_ok)
    );

    `PTC_ASSERT_IMP(a_blocked_only_by_output, !sample.ready, result.valid && !result.ready)

endmodule

### rtl/core/ptc_front.sv
// First-order stages: temperature difference, coefficient products, TEMP/OFF/SENS and T2
`include "pressure_temperature_compensation_defines.svh"
module ptc_front import ptc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RAW_W-1:0] raw_pressure,
    input  logic [RAW_W-1:0] raw_temperature,
    output logic             out_valid,
    input  logic             out_ready,
    output first_order_t     out_data
);

    localparam int unsigned PROD_W     = DT_W + COEF_W + 1;
    localparam int unsigned DT_SQ_W    = 2 * DT_W - 1;
    localparam int unsigned SQ3_W      = DT_SQ_W + 2;
    localparam int unsigned SQ7_W      = DT_SQ_W + 3;
    localparam int unsigned TEMP_SHIFT = 23;
    localparam int unsigned OFF_SHIFT  = 7;
    localparam int unsigned SENS_SHIFT = 8;
    localparam int unsigned T2C_SHIFT  = 33;
    localparam int unsigned T2W_SHIFT  = 37;
    localparam int unsigned T2_W       = SQ3_W - T2C_SHIFT;
    localparam int unsigned T2W_W      = SQ7_W - T2W_SHIFT;

    logic [2:0] vld_reg;
    logic [2:0] adv;

    // Stage 1
    logic [RAW_W-1:0]       d1_s1_reg;
    logic signed [DT_W-1:0] dt_next;
    logic signed [DT_W-1:0] dt_reg;

    // Stage 2
    logic [RAW_W-1:0]          d1_s2_reg;
    logic signed [PROD_W-1:0]  slope_prod_next, off_prod_next, sens_prod_next;
    logic signed [PROD_W-1:0]  slope_prod_reg, off_prod_reg, sens_prod_reg;
    logic signed [2*DT_W-1:0]  dt_prod;
    logic [DT_SQ_W-1:0]        dt_sq_next;
    logic [DT_SQ_W-1:0]        dt_sq_reg;

    // Stage 3
    logic signed [DEV_W-1:0]  dev;
    logic signed [TEMP_W-1:0] temp1;
    logic [SQ3_W-1:0]         sq3;
    logic [SQ7_W-1:0]         sq7;
    logic [T2_W-1:0]          t2;
    first_order_t             fo_next;
    first_order_t             fo_reg;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        adv[2] = !vld_reg[2] || out_ready;
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[2];
    assign out_data  = fo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    // Stage 1: temperature difference against the reference word
    assign dt_next = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, cfg.ref_temp_coef, 8'h00});

    // Stage 2: coefficient products and the squared difference
    always_comb
    begin
        slope_prod_next = dt_reg * $signed({1'b0, cfg.temp_slope_coef});
        off_prod_next   = dt_reg * $signed({1'b0, cfg.off_temp_coef});
        sens_prod_next  = dt_reg * $signed({1'b0, cfg.sens_temp_coef});
        dt_prod         = dt_reg * dt_reg;
        dt_sq_next      = dt_prod[DT_SQ_W-1:0];
    end

    // Stage 3: first-order TEMP, OFF, SENS and the T2 correction
    always_comb
    begin
        dev   = slope_prod_reg[TEMP_SHIFT+DEV_W-1:TEMP_SHIFT];
        temp1 = $signed({dev[DEV_W-1], dev}) + TEMP_REF;
        sq3   = {2'b00, dt_sq_reg} + {1'b0, dt_sq_reg, 1'b0};
        sq7   = {dt_sq_reg, 3'b000} - {3'b000, dt_sq_reg};
        if (dev[DEV_W-1])
        begin
            t2 = sq3[SQ3_W-1:T2C_SHIFT];
        end
        else
        begin
            t2 = {{(T2_W-T2W_W){1'b0}}, sq7[SQ7_W-1:T2W_SHIFT]};
        end
        fo_next.raw_pressure = d1_s2_reg;
        fo_next.temperature  = temp1 - $signed({1'b0, t2});
        fo_next.dev          = dev;
        fo_next.cold         = dev + COLD_SHIFT;
        fo_next.off          = $signed({4'h0, cfg.off_coef, 16'h0000})
                             + $signed({off_prod_reg[PROD_W-1],
                                        off_prod_reg[PROD_W-1:OFF_SHIFT]});
        fo_next.sens         = $signed({4'h0, cfg.sens_coef, 15'h0000})
                             + $signed({sens_prod_reg[PROD_W-1],
                                        sens_prod_reg[PROD_W-1:SENS_SHIFT]});
        fo_next.cold_range   = dev[DEV_W-1];
        fo_next.very_cold    = dev < VERY_COLD_DEV;
    end

    // Load each stage's payload as it advances
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d1_s1_reg <= raw_pressure;
            dt_reg    <= dt_next;
        end
        if (adv[1])
        begin
            d1_s2_reg      <= d1_s1_reg;
            slope_prod_reg <= slope_prod_next;
            off_prod_reg   <= off_prod_next;
            sens_prod_reg  <= sens_prod_next;
            dt_sq_reg      <= dt_sq_next;
        end
        if (adv[2])
        begin
            fo_reg <= fo_next;
        end
    end

    `PTC_ASSERT_IMP(a_very_cold_is_cold, vld_reg[2] && fo_reg.very_cold, fo_reg.cold_range)
    `PTC_ASSERT_NXT(a_fo_held_on_stall, vld_reg[2] && !out_ready, vld_reg[2] && $stable(fo_reg))

endmodule

### rtl/core/ptc_corr.sv
// Second-order stages: squared deviations, OFF2/SENS2 terms and the corrected OFF and SENS
`include "pressure_temperature_compensation_defines.svh"
module ptc_corr import ptc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  first_order_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output second_order_t out_data
);

    logic [2:0] vld_reg;
    logic [2:0] adv;

    // Stage 4
    logic signed [2*DEV_W-1:0] dev_prod, cold_prod;
    logic [SQ_W-1:0]           dev_sq_reg, cold_sq_reg;
    logic [RAW_W-1:0]          d1_s4_reg;
    logic signed [TEMP_W-1:0]  temp_s4_reg;
    logic signed [OFF1_W-1:0]  off_s4_reg;
    logic signed [SENS1_W-1:0] sens_s4_reg;
    logic                      cold_s4_reg, vcold_s4_reg;

    // Stage 5
    logic [TERM_W-1:0]         dev_x3, dev_x5, cold_x7;
    logic [TERM_W-1:0]         off_a_next, off_b_next, sens_a_next, sens_b_next;
    logic [TERM_W-1:0]         off_a_reg, off_b_reg, sens_a_reg, sens_b_reg;
    logic [RAW_W-1:0]          d1_s5_reg;
    logic signed [TEMP_W-1:0]  temp_s5_reg;
    logic signed [OFF1_W-1:0]  off_s5_reg;
    logic signed [SENS1_W-1:0] sens_s5_reg;

    // Stage 6
    logic signed [FIN_W-1:0] off_ext, sens_ext;
    second_order_t           so_next;
    second_order_t           so_reg;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        adv[2] = !vld_reg[2] || out_ready;
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[2];
    assign out_data  = so_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    // Stage 4: square the deviation from 20 degC and from -15 degC
    assign dev_prod  = in_data.dev * in_data.dev;
    assign cold_prod = in_data.cold * in_data.cold;

    // Stage 5: scale the squares per temperature range
    always_comb
    begin
        dev_x3  = {3'b000, dev_sq_reg} + {2'b00, dev_sq_reg, 1'b0};
        dev_x5  = {3'b000, dev_sq_reg} + {1'b0, dev_sq_reg, 2'b00};
        cold_x7 = {cold_sq_reg, 3'b000} - {3'b000, cold_sq_reg};
        off_b_next  = '0;
        sens_b_next = '0;
        if (cold_s4_reg)
        begin
            off_a_next  = dev_x3 >> 1;
            sens_a_next = dev_x5 >> 3;
            if (vcold_s4_reg)
            begin
                off_b_next  = cold_x7;
                sens_b_next = {1'b0, cold_sq_reg, 2'b00};
            end
        end
        else
        begin
            off_a_next  = {3'b000, dev_sq_reg} >> 4;
            sens_a_next = '0;
        end
    end

    // Stage 6: subtract the second-order terms
    always_comb
    begin
        off_ext  = {{(FIN_W-OFF1_W){off_s5_reg[OFF1_W-1]}}, off_s5_reg};
        sens_ext = {{(FIN_W-SENS1_W){sens_s5_reg[SENS1_W-1]}}, sens_s5_reg};
        so_next.raw_pressure = d1_s5_reg;
        so_next.temperature  = temp_s5_reg;
        so_next.off  = off_ext - $signed({1'b0, off_a_reg}) - $signed({1'b0, off_b_reg});
        so_next.sens = sens_ext - $signed({1'b0, sens_a_reg}) - $signed({1'b0, sens_b_reg});
    end

    // Load each stage's payload as it advances
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dev_sq_reg   <= dev_prod[SQ_W-1:0];
            cold_sq_reg  <= cold_prod[SQ_W-1:0];
            d1_s4_reg    <= in_data.raw_pressure;
            temp_s4_reg  <= in_data.temperature;
            off_s4_reg   <= in_data.off;
            sens_s4_reg  <= in_data.sens;
            cold_s4_reg  <= in_data.cold_range;
            vcold_s4_reg <= in_data.very_cold;
        end
        if (adv[1])
        begin
            off_a_reg   <= off_a_next;
            off_b_reg   <= off_b_next;
            sens_a_reg  <= sens_a_next;
            sens_b_reg  <= sens_b_next;
            d1_s5_reg   <= d1_s4_reg;
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s4_reg;
            sens_s5_reg <= sens_s4_reg;
        end
        if (adv[2])
        begin
            so_reg <= so_next;
        end
    end

    `PTC_ASSERT_NXT(a_warm_no_sens2, vld_reg[0] && adv[1] && !cold_s4_reg,
                    (sens_a_reg == '0) && (sens_b_reg == '0) && (off_b_reg == '0))

endmodule

### rtl/core/ptc_press.sv
// Pressure stages: split D1*SENS product, scaling, offset removal and window check
module ptc_press import ptc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [LIMIT_W-1:0] low_limit,
    input  logic signed [LIMIT_W-1:0] high_limit,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  second_order_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [TEMP_W-1:0]  temperature,
    output logic signed [PRES_W-1:0]  pressure,
    output logic                      pressure_ok
);

    localparam int unsigned SPLIT   = 20;
    localparam int unsigned LO_W    = RAW_W + SPLIT;
    localparam int unsigned HI_W    = RAW_W + 1 + FIN_W - SPLIT;
    localparam int unsigned FULL_W  = 64;
    localparam int unsigned P_SHIFT = 21;
    localparam int unsigned SC_W    = FULL_W - P_SHIFT;
    localparam int unsigned Q_W     = SC_W + 1;
    localparam int unsigned Q_SHIFT = 15;
    localparam int unsigned PV_W    = Q_W - Q_SHIFT;

    logic [3:0] vld_reg;
    logic [3:0] adv;

    // Stage 7
    logic [LO_W-1:0]          lo_next, lo_reg;
    logic signed [HI_W-1:0]   hi_next, hi_reg;
    logic signed [FIN_W-1:0]  off_s7_reg;
    logic signed [TEMP_W-1:0] temp_s7_reg;

    // Stage 8
    logic signed [FULL_W-1:0] full;
    logic signed [SC_W-1:0]   sc_reg;
    logic signed [FIN_W-1:0]  off_s8_reg;
    logic signed [TEMP_W-1:0] temp_s8_reg;

    // Stage 9
    logic signed [Q_W-1:0]    q_next, q_reg;
    logic signed [TEMP_W-1:0] temp_s9_reg;

    // Stage 10
    logic signed [PRES_W-1:0] pres_next, pres_reg;
    logic                     ok_next, ok_reg;
    logic signed [TEMP_W-1:0] temp_out_reg;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        adv[3] = !vld_reg[3] || out_ready;
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign in_ready    = adv[0];
    assign out_valid   = vld_reg[3];
    assign temperature = temp_out_reg;
    assign pressure    = pres_reg;
    assign pressure_ok = ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
            if (adv[3])
            begin
                vld_reg[3] <= vld_reg[2];
            end
        end
    end

    // Stage 7: D1 times the low and high halves of SENS
    assign lo_next = in_data.raw_pressure * in_data.sens[SPLIT-1:0];
    assign hi_next = $signed({1'b0, in_data.raw_pressure}) * $signed(in_data.sens[FIN_W-1:SPLIT]);

    // Stage 8: recombine the halves and drop 21 fraction bits
    assign full = $signed({hi_reg, {SPLIT{1'b0}}}) + $signed({{(FULL_W-LO_W){1'b0}}, lo_reg});

    // Stage 9: remove the offset
    assign q_next = $signed({sc_reg[SC_W-1], sc_reg})
                  - $signed({{(Q_W-FIN_W){off_s8_reg[FIN_W-1]}}, off_s8_reg});

    // Stage 10: drop 15 fraction bits and check the window
    always_comb
    begin
        pres_next = $signed({{(PRES_W-PV_W){q_reg[Q_W-1]}}, q_reg[Q_W-1:Q_SHIFT]});
        ok_next   = (pres_next >= low_limit) && (pres_next <= high_limit);
    end

    // Load each stage's payload as it advances
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            off_s7_reg  <= in_data.off;
            temp_s7_reg <= in_data.temperature;
        end
        if (adv[1])
        begin
            sc_reg      <= full[FULL_W-1:P_SHIFT];
            off_s8_reg  <= off_s7_reg;
            temp_s8_reg <= temp_s7_reg;
        end
        if (adv[2])
        begin
            q_reg       <= q_next;
            temp_s9_reg <= temp_s8_reg;
        end
        if (adv[3])
        begin
            pres_reg     <= pres_next;
            ok_reg       <= ok_next;
            temp_out_reg <= temp_s9_reg;
        end
    end

endmodule

### tb/sv/pressure_temperature_compensation_test.sv
// Self-checking testbench for the second-order pressure/temperature compensation pipeline
`timescale 1ns / 1ps

module pressure_temperature_compensation_test;
    import ptc_pkg::*;

    // One compensated reading as the result channel carries it
    typedef struct {
        logic signed [TEMP_W-1:0] temperature;
        logic signed [PRES_W-1:0] pressure;
        logic                     pressure_ok;
    } reading_t;

    // Predicts readings from raw pairs and checks them in arrival order
    class compensation_board;
        logic [COEF_W-1:0]         coef [6];
        logic signed [LIMIT_W-1:0] low_limit;
        logic signed [LIMIT_W-1:0] high_limit;
        reading_t                  expected_readings [$];
        int                        mismatches;

        function new();
            foreach (coef[i]) coef[i] = '0;
            low_limit  = '0;
            high_limit = HIGH_LIMIT_RST;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [LIMIT_W-1:0] value);
            case (idx)
                REG_LOW_LIMIT:  low_limit = value;
                REG_HIGH_LIMIT: high_limit = value;
                default:        coef[idx] = value[COEF_W-1:0];
            endcase
        endfunction

        // Second-order compensation; every >>> on a longint rounds toward minus infinity
        function reading_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
            longint   d1, d2, dt, temp, off, sens, t2, off2, sens2, dev, cold, p;
            reading_t r;
            d1   = longint'(d1_raw);
            d2   = longint'(d2_raw);
            dt   = d2 - longint'(coef[REG_REF_TEMP]) * 256;
            temp = 2000 + ((dt * longint'(coef[REG_TEMP_SLOPE])) >>> 23);
            off  = longint'(coef[REG_OFF]) * 65536
                   + ((longint'(coef[REG_OFF_TEMP]) * dt) >>> 7);
            sens = longint'(coef[REG_SENS]) * 32768
                   + ((longint'(coef[REG_SENS_TEMP]) * dt) >>> 8);
            dev  = temp - 2000;
            if (temp < 2000)
            begin
                t2    = (3 * dt * dt) >>> 33;
                off2  = (3 * dev * dev) >>> 1;
                sens2 = (5 * dev * dev) >>> 3;
                // very cold branch adds a further quadratic term
                if (temp < -1500)
                begin
                    cold  = temp + 1500;
                    off2  = off2 + 7 * cold * cold;
                    sens2 = sens2 + 4 * cold * cold;
                end
            end
            else
            begin
                t2    = (7 * dt * dt) >>> 37;
                off2  = (dev * dev) >>> 4;
                sens2 = 0;
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
            p    = (((d1 * sens) >>> 21) - off) >>> 15;
            r.temperature = temp[TEMP_W-1:0];
            r.pressure    = p[PRES_W-1:0];
            r.pressure_ok = (p >= longint'(low_limit)) && (p <= longint'(high_limit));
            return r;
        endfunction

        function void note_sample(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
            expected_readings.push_back(compensate(d1_raw, d2_raw));
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic signed [TEMP_W-1:0] temperature,
                          logic signed [PRES_W-1:0] pressure, logic pressure_ok);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                report($sformatf("unexpected result temperature=%0d pressure=%0d",
                                 temperature, pressure));
                return;
            end
            want = expected_readings.pop_front();
            if (temperature !== want.temperature)
                report($sformatf("temperature got %0d want %0d", temperature,
                                 want.temperature));
            if (pressure !== want.pressure)
                report($sformatf("pressure got %0d want %0d", pressure, want.pressure));
            if (pressure_ok !== want.pressure_ok)
                report($sformatf("pressure_ok got %0b want %0b (pressure %0d)",
                                 pressure_ok, want.pressure_ok, want.pressure));
        endtask
    endclass

    localparam logic [COEF_W-1:0] TYPICAL_COEF [6] = '{46372, 43981, 29059, 27842, 31553, 28165};
    localparam logic [RAW_W-1:0]  RAW_MAX   = '1;
    localparam logic [RAW_W-1:0]  MID_SCALE = 24'h800000;
    localparam logic signed [LIMIT_W-1:0] LIMIT_MIN = 32'sh8000_0000;
    localparam logic signed [LIMIT_W-1:0] LIMIT_MAX = 32'sh7FFF_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [LIMIT_W-1:0]   wr_data;
    int                   results_taken;

    ptc_sample_if sample_ch ();
    ptc_result_if result_ch ();

    compensation_board sb = new();

    pressure_temperature_compensation u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sample   (sample_ch),
        .result   (result_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Give up on a hung pipeline
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Check every accepted result request against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sb.check_result(result_ch.temperature, result_ch.pressure, result_ch.pressure_ok);
            results_taken++;
        end
    end

    // Drive result ready: random stall modes, plus one long hold-off to back up the pipeline
    initial
    begin
        int  stall_mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        stall_mode = 0;
        mode_left  = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_taken >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 9) != 0);
                    default: result_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Offer one raw pair and hold it until the pipeline takes it
    task automatic send_sample(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
        @(negedge clk);
        sample_ch.valid           <= 1'b1;
        sample_ch.raw_pressure    <= d1_raw;
        sample_ch.raw_temperature <= d2_raw;
        do @(posedge clk); while (!sample_ch.ready);
        sb.note_sample(d1_raw, d2_raw);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [LIMIT_W-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        sb.set_reg(idx, value);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_coefs(logic [COEF_W-1:0] c [6]);
        for (int i = 0; i < 6; i++)
            write_reg(cfg_idx_t'(i), {16'd0, c[i]});
    endtask

    task automatic load_window(logic signed [LIMIT_W-1:0] lo, logic signed [LIMIT_W-1:0] hi);
        write_reg(REG_LOW_LIMIT, lo);
        write_reg(REG_HIGH_LIMIT, hi);
    endtask

    // Drop valid, let every outstanding request come out, then cover the pipeline depth
    task automatic wait_idle();
        idle_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Raw temperature: mostly near the reference point at a random scale, else anywhere
    function automatic logic [RAW_W-1:0] pick_raw_temperature();
        longint center;
        longint offset;
        longint d2;
        if ($urandom_range(0, 9) < 4)
            return RAW_W'($urandom_range(0, RAW_MAX));
        center = longint'(sb.coef[REG_REF_TEMP]) * 256;
        offset = longint'($urandom_range(0, (1 << $urandom_range(4, 23)) - 1));
        if ($urandom_range(0, 1))
            offset = -offset;
        d2 = center + offset;
        if (d2 < 0)
            d2 = 0;
        if (d2 > longint'(RAW_MAX))
            d2 = longint'(RAW_MAX);
        return d2[RAW_W-1:0];
    endfunction

    // New calibration words and window for one random phase
    task automatic randomize_settings();
        logic [COEF_W-1:0]         c [6];
        logic signed [LIMIT_W-1:0] lo;
        logic signed [LIMIT_W-1:0] hi;
        int                        coef_kind;
        reading_t                  probe;
        coef_kind = $urandom_range(0, 3);
        for (int i = 0; i < 6; i++)
        begin
            case (coef_kind)
                0, 1:    c[i] = COEF_W'(TYPICAL_COEF[i] + $urandom_range(0, 8000) - 4000);
                2:       c[i] = COEF_W'($urandom_range(0, 65535));
                default: c[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
        end
        load_coefs(c);
        case ($urandom_range(0, 3))
            0:
            begin
                lo = $urandom_range(0, 2000);
                hi = $urandom_range(20000, 140000);
            end
            1:
            begin
                lo = LIMIT_MIN;
                hi = LIMIT_MAX;
            end
            2:
            begin
                lo = $urandom_range(1000, 200000);
                hi = lo - $urandom_range(1, 1000);
            end
            default:
            begin
                probe = sb.compensate(RAW_W'($urandom_range(0, RAW_MAX)),
                                      pick_raw_temperature());
                lo = probe.pressure - $urandom_range(0, 5000);
                hi = probe.pressure + $urandom_range(0, 5000);
            end
        endcase
        load_window(lo, hi);
    endtask

    // Random pairs in bursts of random length with random gaps
    task automatic run_random_phase(int n_items);
        int burst_left;
        burst_left = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 6));
            end
            burst_left--;
            send_sample(RAW_W'($urandom_range(0, RAW_MAX)), pick_raw_temperature());
        end
    endtask

    initial
    begin
        reading_t probe;
        sample_ch.valid           <= 1'b0;
        sample_ch.raw_pressure    <= '0;
        sample_ch.raw_temperature <= '0;
        wr_en                     <= 1'b0;
        wr_index                  <= REG_SENS;
        wr_data                   <= '0;
        rst_n                     <= 1'b0;
        results_taken = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: all calibration words zero
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        wait_idle();

        // Full-scale words; slope 2^15 puts the branch edges on exact raw values
        load_coefs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000});
        load_window(LIMIT_MIN, LIMIT_MAX);
        send_sample(RAW_MAX, MID_SCALE);                         // dT zero
        send_sample(RAW_MAX, RAW_W'(MID_SCALE + 255));           // just warm
        send_sample(RAW_MAX, RAW_W'(MID_SCALE - 1));             // just cold
        send_sample(RAW_MAX, RAW_W'(MID_SCALE - 896000));        // at the very cold edge
        send_sample(RAW_MAX, RAW_W'(MID_SCALE - 896001));        // just very cold
        send_sample(RAW_MAX, '0);
        send_sample('0, RAW_MAX);
        wait_idle();

        // Typical words across the warm, cold and very cold ranges
        load_coefs(TYPICAL_COEF);
        load_window('0, HIGH_LIMIT_RST);
        send_sample(24'd4311550, 24'd8387300);
        send_sample(24'd4311550, 24'd8077568);
        send_sample('0, 24'd7877568);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, RAW_MAX);
        send_sample(24'd8000000, 24'd7000000);
        wait_idle();

        // Inverted window rejects everything
        load_window(HIGH_LIMIT_RST, '0);
        send_sample(24'd4311550, 24'd8387300);
        send_sample(24'd9000000, 24'd6000000);
        wait_idle();

        // Window of one value: inclusive at both ends, then just missed
        probe = sb.compensate(24'd4311550, 24'd8387300);
        load_window(probe.pressure, probe.pressure);
        send_sample(24'd4311550, 24'd8387300);
        wait_idle();
        write_reg(REG_LOW_LIMIT, probe.pressure + 1);
        send_sample(24'd4311550, 24'd8387300);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            randomize_settings();
            run_random_phase(148);
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ptc_pkg.sv
rtl/core/ptc_if.sv
rtl/core/ptc_front.sv
rtl/core/ptc_corr.sv
rtl/core/ptc_press.sv
rtl/core/pressure_temperature_compensation.sv
tb/sv/pressure_temperature_compensation_test.sv
